[design/edf_pkg.sv]
// Shared types and codes for the deadline-ordered job dispatcher.
// No dependencies; compile first.
package edf_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;

   localparam int TIME_W  = 32;
   localparam int NUM_W   = 16;
   localparam int TOTAL_W = 48;

   // func codes
   localparam logic FN_ENQUEUE  = 1'b0;
   localparam logic FN_DISPATCH = 1'b1;

   // status codes
   localparam logic [1:0] ST_ENQUEUED   = 2'd0;
   localparam logic [1:0] ST_DISPATCHED = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;
   localparam logic [1:0] ST_EMPTY      = 2'd3;

   // one stored job
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] length;
      logic [NUM_W-1:0]  number;
      logic [TIME_W-1:0] age;
   } entry_type;

endpackage

[design/edf_req_if.sv]
// Request channel: one job word in (enqueue or dispatch).
// Depends on edf_pkg.
interface edf_req_if;
   import edf_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [TIME_W-1:0] arrival_time;
   logic [TIME_W-1:0] due_time;
   logic [TIME_W-1:0] run_length;

   modport source (output valid, func, arrival_time, due_time, run_length, input ready);
   modport sink   (input valid, func, arrival_time, due_time, run_length, output ready);
endinterface

[design/edf_rsp_if.sv]
// Response channel: one result word out per request word.
// Depends on edf_pkg.
interface edf_rsp_if;
   import edf_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [NUM_W-1:0]   job_number;
   logic [TIME_W-1:0]  run_start;
   logic [TIME_W-1:0]  wait_ticks;
   logic [TIME_W-1:0]  finish_time;
   logic [TOTAL_W-1:0] wait_total;
   logic [TOTAL_W-1:0] turnaround_total;
   logic [TIME_W-1:0]  jobs_done;

   modport source (output valid, status, job_number, run_start, wait_ticks, finish_time,
                   wait_total, turnaround_total, jobs_done, input ready);
   modport sink   (input valid, status, job_number, run_start, wait_ticks, finish_time,
                   wait_total, turnaround_total, jobs_done, output ready);
endinterface

[design/edf_nonpreemptive_dispatcher_top.sv]
// Non-preemptive earliest-deadline-first dispatcher, top level.
// Enqueue: one valid bit looked at per cycle in the hunt for the lowest free entry.
// Dispatch: two passes over the job store through its single read port, one word a cycle,
// then two arithmetic steps. One word at a time.
// Synchronous active-high reset clears valid bits, counters, time and totals at once.
// Depends on edf_pkg, edf_req_if, edf_rsp_if, edf_table.
module edf_nonpreemptive_dispatcher_top #(
   parameter int TABLE_ENTRIES = edf_pkg::DEF_TABLE_ENTRIES
) (
   input logic    clock,
   input logic    reset,
   edf_req_if.sink   req_chan,
   edf_rsp_if.source rsp_chan
);
   import edf_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request word
   localparam logic [2:0] S_FREE = 3'd1;  // hunt for lowest free entry
   localparam logic [2:0] S_ARR  = 3'd2;  // pass 1: earliest stored arrival
   localparam logic [2:0] S_ADV  = 3'd3;  // idle time jumps forward
   localparam logic [2:0] S_PICK = 3'd4;  // pass 2: earliest deadline among ready jobs
   localparam logic [2:0] S_CALC = 3'd5;  // wait, finish, turnaround increment
   localparam logic [2:0] S_ACC  = 3'd6;  // saturating totals
   localparam logic [2:0] S_OUT  = 3'd7;  // hand result to output register

   logic [2:0] state_ff, state_in;

   // request word held for the duration of the job
   logic [TIME_W-1:0] in_arr_ff, in_arr_in;
   logic [TIME_W-1:0] in_due_ff, in_due_in;
   logic [TIME_W-1:0] in_len_ff, in_len_in;

   // scan index and read pipeline tag (travels alongside the registered read data)
   logic [IW-1:0] idx_ff, idx_in;
   logic          issue_ff, issue_in;
   logic          tag_ok_ff, tag_ok_in;
   logic          tag_vld_ff, tag_vld_in;
   logic          tag_last_ff, tag_last_in;
   logic [IW-1:0] tag_idx_ff, tag_idx_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // architectural state
   logic [TIME_W-1:0]  seq_ff, seq_in;
   logic [NUM_W-1:0]   next_num_ff, next_num_in;
   logic [TIME_W-1:0]  cur_ff, cur_in;
   logic [TOTAL_W-1:0] sum_wait_ff, sum_wait_in;
   logic [TOTAL_W-1:0] sum_turn_ff, sum_turn_in;
   logic [TIME_W-1:0]  done_ff, done_in;

   // pass 1 / pass 2 bookkeeping
   logic              have_ff, have_in;
   logic [TIME_W-1:0] min_arr_ff, min_arr_in;
   logic [IW-1:0]     pick_idx_ff, pick_idx_in;
   logic [TIME_W-1:0] best_due_ff, best_due_in;
   logic [TIME_W-1:0] best_age_ff, best_age_in;
   logic [TIME_W-1:0] pick_arr_ff, pick_arr_in;
   logic [TIME_W-1:0] pick_len_ff, pick_len_in;
   logic [NUM_W-1:0]  pick_num_ff, pick_num_in;
   logic [TIME_W:0]   turn_inc_ff, turn_inc_in;

   // result being assembled
   logic [1:0]        res_status_ff, res_status_in;
   logic [NUM_W-1:0]  res_num_ff, res_num_in;
   logic [TIME_W-1:0] res_start_ff, res_start_in;
   logic [TIME_W-1:0] res_wait_ff, res_wait_in;
   logic [TIME_W-1:0] res_fin_ff, res_fin_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]   rsp_num_ff, rsp_num_in;
   logic [TIME_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [TIME_W-1:0]  rsp_wait_ff, rsp_wait_in;
   logic [TIME_W-1:0]  rsp_fin_ff, rsp_fin_in;
   logic [TOTAL_W-1:0] rsp_wtot_ff, rsp_wtot_in;
   logic [TOTAL_W-1:0] rsp_ttot_ff, rsp_ttot_in;
   logic [TIME_W-1:0]  rsp_done_ff, rsp_done_in;

   // job store port
   logic      wr_en;
   entry_type wr_data;
   entry_type rd_data;

   edf_table #(
      .ENTRIES (TABLE_ENTRIES),
      .IW      (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   logic out_free;
   logic req_fire;
   logic elig;
   logic better;
   logic [TIME_W:0]    fin_sum;
   logic [TIME_W-1:0]  wait_val;
   logic [TOTAL_W:0]   wsum;
   logic [TOTAL_W:0]   tsum;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   // pass 2 comparison on the word coming out of the store
   assign elig   = tag_vld_ff && (rd_data.arrival <= cur_ff);
   assign better = !have_ff || (rd_data.due < best_due_ff) ||
                   ((rd_data.due == best_due_ff) && (rd_data.age > best_age_ff));

   // dispatched job arithmetic; the job is ready so cur >= arrival here
   assign wait_val = cur_ff - pick_arr_ff;
   assign fin_sum  = {1'b0, cur_ff} + {1'b0, pick_len_ff};
   assign wsum     = {1'b0, sum_wait_ff} + (TOTAL_W+1)'(res_wait_ff);
   assign tsum     = {1'b0, sum_turn_ff} + (TOTAL_W+1)'(turn_inc_ff);

   assign wr_data.arrival = in_arr_ff;
   assign wr_data.due     = in_due_ff;
   assign wr_data.length  = in_len_ff;
   assign wr_data.number  = next_num_ff;
   assign wr_data.age     = seq_ff;

   always_comb begin
      state_in      = state_ff;
      in_arr_in     = in_arr_ff;
      in_due_in     = in_due_ff;
      in_len_in     = in_len_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      tag_ok_in     = 1'b0;
      tag_vld_in    = tag_vld_ff;
      tag_last_in   = tag_last_ff;
      tag_idx_in    = tag_idx_ff;
      valid_in      = valid_ff;
      seq_in        = seq_ff;
      next_num_in   = next_num_ff;
      cur_in        = cur_ff;
      sum_wait_in   = sum_wait_ff;
      sum_turn_in   = sum_turn_ff;
      done_in       = done_ff;
      have_in       = have_ff;
      min_arr_in    = min_arr_ff;
      pick_idx_in   = pick_idx_ff;
      best_due_in   = best_due_ff;
      best_age_in   = best_age_ff;
      pick_arr_in   = pick_arr_ff;
      pick_len_in   = pick_len_ff;
      pick_num_in   = pick_num_ff;
      turn_inc_in   = turn_inc_ff;
      res_status_in = res_status_ff;
      res_num_in    = res_num_ff;
      res_start_in  = res_start_ff;
      res_wait_in   = res_wait_ff;
      res_fin_in    = res_fin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_wtot_in   = rsp_wtot_ff;
      rsp_ttot_in   = rsp_ttot_ff;
      rsp_done_in   = rsp_done_ff;
      wr_en         = 1'b0;

      // read issue for either pass: one address a cycle, tag follows the data
      if (issue_ff) begin
         tag_ok_in   = 1'b1;
         tag_vld_in  = valid_ff[idx_ff];
         tag_last_in = (idx_ff == LAST_IDX);
         tag_idx_in  = idx_ff;
         idx_in      = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               in_arr_in    = req_chan.arrival_time;
               in_due_in    = req_chan.due_time;
               in_len_in    = req_chan.run_length;
               idx_in       = '0;
               have_in      = 1'b0;
               res_num_in   = '0;
               res_start_in = '0;
               res_wait_in  = '0;
               res_fin_in   = '0;
               if (req_chan.func == FN_ENQUEUE) begin
                  state_in = S_FREE;
               end else begin
                  issue_in = 1'b1;
                  state_in = S_ARR;
               end
            end
         end

         S_FREE: begin
            if (!valid_ff[idx_ff]) begin
               wr_en            = 1'b1;
               valid_in[idx_ff] = 1'b1;
               res_status_in    = ST_ENQUEUED;
               res_num_in       = next_num_ff;
               next_num_in      = next_num_ff + 1'b1;
               seq_in           = seq_ff + 1'b1;
               state_in         = S_OUT;
            end else if (idx_ff == LAST_IDX) begin
               res_status_in = ST_FULL;
               state_in      = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_ARR: begin
            if (tag_ok_ff) begin
               if (tag_vld_ff && (!have_ff || (rd_data.arrival < min_arr_ff))) begin
                  have_in    = 1'b1;
                  min_arr_in = rd_data.arrival;
               end
               if (tag_last_ff) begin
                  state_in = S_ADV;
               end
            end
         end

         S_ADV: begin
            if (!have_ff) begin
               res_status_in = ST_EMPTY;
               state_in      = S_OUT;
            end else begin
               if (min_arr_ff > cur_ff) begin
                  cur_in = min_arr_ff;
               end
               have_in  = 1'b0;
               idx_in   = '0;
               issue_in = 1'b1;
               state_in = S_PICK;
            end
         end

         S_PICK: begin
            if (tag_ok_ff) begin
               if (elig && better) begin
                  have_in     = 1'b1;
                  pick_idx_in = tag_idx_ff;
                  best_due_in = rd_data.due;
                  best_age_in = rd_data.age;
                  pick_arr_in = rd_data.arrival;
                  pick_len_in = rd_data.length;
                  pick_num_in = rd_data.number;
               end
               if (tag_last_ff) begin
                  state_in = S_CALC;
               end
            end
         end

         S_CALC: begin
            valid_in[pick_idx_ff] = 1'b0;
            res_status_in = ST_DISPATCHED;
            res_num_in    = pick_num_ff;
            res_start_in  = cur_ff;
            res_wait_in   = wait_val;
            res_fin_in    = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
            cur_in        = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
            turn_inc_in   = {1'b0, wait_val} + {1'b0, pick_len_ff};
            state_in      = S_ACC;
         end

         S_ACC: begin
            sum_wait_in = wsum[TOTAL_W] ? '1 : wsum[TOTAL_W-1:0];
            sum_turn_in = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
            if (done_ff != '1) begin
               done_in = done_ff + 1'b1;
            end
            state_in = S_OUT;
         end

         S_OUT: begin
            // holds here until the output register has room
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_num_in    = res_num_ff;
               rsp_start_in  = res_start_ff;
               rsp_wait_in   = res_wait_ff;
               rsp_fin_in    = res_fin_ff;
               rsp_wtot_in   = sum_wait_ff;
               rsp_ttot_in   = sum_turn_ff;
               rsp_done_in   = done_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         tag_ok_ff    <= 1'b0;
         valid_ff     <= '0;
         seq_ff       <= '0;
         next_num_ff  <= '0;
         cur_ff       <= '0;
         sum_wait_ff  <= '0;
         sum_turn_ff  <= '0;
         done_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         issue_ff     <= issue_in;
         tag_ok_ff    <= tag_ok_in;
         valid_ff     <= valid_in;
         seq_ff       <= seq_in;
         next_num_ff  <= next_num_in;
         cur_ff       <= cur_in;
         sum_wait_ff  <= sum_wait_in;
         sum_turn_ff  <= sum_turn_in;
         done_ff      <= done_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_arr_ff     <= in_arr_in;
      in_due_ff     <= in_due_in;
      in_len_ff     <= in_len_in;
      tag_vld_ff    <= tag_vld_in;
      tag_last_ff   <= tag_last_in;
      tag_idx_ff    <= tag_idx_in;
      min_arr_ff    <= min_arr_in;
      pick_idx_ff   <= pick_idx_in;
      best_due_ff   <= best_due_in;
      best_age_ff   <= best_age_in;
      pick_arr_ff   <= pick_arr_in;
      pick_len_ff   <= pick_len_in;
      pick_num_ff   <= pick_num_in;
      turn_inc_ff   <= turn_inc_in;
      res_status_ff <= res_status_in;
      res_num_ff    <= res_num_in;
      res_start_ff  <= res_start_in;
      res_wait_ff   <= res_wait_in;
      res_fin_ff    <= res_fin_in;
      rsp_status_ff <= rsp_status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_wtot_ff   <= rsp_wtot_in;
      rsp_ttot_ff   <= rsp_ttot_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.job_number       = rsp_num_ff;
   assign rsp_chan.run_start        = rsp_start_ff;
   assign rsp_chan.wait_ticks       = rsp_wait_ff;
   assign rsp_chan.finish_time      = rsp_fin_ff;
   assign rsp_chan.wait_total       = rsp_wtot_ff;
   assign rsp_chan.turnaround_total = rsp_ttot_ff;
   assign rsp_chan.jobs_done        = rsp_done_ff;
endmodule

[design/edf_table.sv]
// Job store: single write port, single read port with registered read data.
// Depends on edf_pkg.
module edf_table #(
   parameter int ENTRIES = edf_pkg::DEF_TABLE_ENTRIES,
   parameter int IW      = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  edf_pkg::entry_type  wr_data,
   input  logic [IW-1:0]       rd_addr,
   output edf_pkg::entry_type  rd_data
);
   import edf_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
